// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

	localparam int MODE_W   = 3;
	localparam int SLOT_IO_W = 4;
	localparam int PERIOD_W = 32;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RUN    = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic accept;
		logic scan_eval;
		logic scan_finish;
	} pts_cmd_t;

	typedef struct packed {
		logic scan_empty;
		logic eval_last;
	} pts_sts_t;

endpackage

`default_nettype wire

// ----- src/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: accepts commands and steps the datapath through a run pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl
	import pts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire pts_sts_t          sts,
	output logic                   busy,
	output pts_cmd_t               cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d         = state_q;
		cmd.accept      = 1'b0;
		cmd.scan_eval   = 1'b0;
		cmd.scan_finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && mode == MODE_RUN && !sts.scan_empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_eval = 1'b1;
				if (sts.eval_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.scan_finish = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- src/pts_dp.sv -----
// ----------------------------------------------------------------------------
// pts_dp
// Tick counter, slot table and result register of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_dp
	import pts_pkg::*;
#(
	parameter int MAX_SLOTS = 16,
	parameter int TICK_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pts_cmd_t             cmd,
	output pts_sts_t                  sts,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [SLOT_IO_W-1:0] slot_index,
	input  wire logic [PERIOD_W-1:0]  period_ticks,
	output logic                      strobe,
	output logic [SLOT_IO_W-1:0]      slot_out,
	output logic [STATUS_W-1:0]       status,
	output logic                      fired,
	output logic                      last_result
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W  = (CNT_W > SLOT_IO_W) ? CNT_W : SLOT_IO_W;
	localparam int CMP_W  = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;

	logic [TICK_BITS-1:0] tick_q;
	logic [CNT_W-1:0]     used_q;
	logic [MAX_SLOTS-1:0] en_q;
	logic [SLOT_W-1:0]    eval_idx_q;
	logic                 pend_valid_q;
	logic [SLOT_W-1:0]    pend_slot_q;

	logic [PERIOD_W-1:0]  period_mem [MAX_SLOTS];
	logic [TICK_BITS-1:0] last_mem   [MAX_SLOTS];
	logic [PERIOD_W-1:0]  period_rd_q;
	logic [TICK_BITS-1:0] last_rd_q;

	logic                 strobe_q;
	logic [SLOT_IO_W-1:0] slot_out_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 fired_q;
	logic                 last_q;

	logic                 is_run;
	logic                 table_full;
	logic                 idx_ok;
	logic [SLOT_W-1:0]    idx_addr;
	logic [SLOT_W-1:0]    new_addr;
	logic [SLOT_W-1:0]    next_addr;
	logic [SLOT_W-1:0]    last_addr;
	logic [TICK_BITS-1:0] elapsed;
	logic                 due;
	logic                 eval_last;

	logic                 pr_we;
	logic                 lr_we;
	logic [SLOT_W-1:0]    lr_addr;
	logic [TICK_BITS-1:0] lr_data;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr;

	logic                 o_strobe;
	logic [SLOT_IO_W-1:0] o_slot;
	logic [STATUS_W-1:0]  o_status;
	logic                 o_fired;
	logic                 o_last;

	assign is_run     = (mode == MODE_RUN);
	assign table_full = (used_q == CNT_W'(MAX_SLOTS));
	assign idx_ok     = (IDX_W'(slot_index) < IDX_W'(used_q));
	assign idx_addr   = SLOT_W'(slot_index);
	assign new_addr   = SLOT_W'(used_q);
	assign next_addr  = eval_idx_q + SLOT_W'(1);
	assign last_addr  = SLOT_W'(used_q - CNT_W'(1));
	assign eval_last  = (eval_idx_q == last_addr);
	assign elapsed    = tick_q - last_rd_q;
	assign due        = en_q[eval_idx_q] && (CMP_W'(elapsed) >= CMP_W'(period_rd_q));

	assign sts.scan_empty = (used_q == '0);
	assign sts.eval_last  = eval_last;

	// table write and read port control
	always_comb begin
		pr_we   = 1'b0;
		lr_we   = 1'b0;
		lr_addr = new_addr;
		lr_data = '0;
		if (cmd.accept) begin
			unique case (mode)
				MODE_CREATE: begin
					if (!table_full) begin
						pr_we = 1'b1;
						lr_we = 1'b1;
					end
				end
				MODE_START: begin
					if (idx_ok) begin
						lr_we   = 1'b1;
						lr_addr = idx_addr;
						lr_data = tick_q;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan_eval && due) begin
			lr_we   = 1'b1;
			lr_addr = eval_idx_q;
			lr_data = tick_q;
		end
	end

	assign rd_en   = (cmd.accept && is_run) || (cmd.scan_eval && !eval_last);
	assign rd_addr = cmd.scan_eval ? next_addr : '0;

	always_ff @(posedge clk) begin
		if (pr_we) begin
			period_mem[new_addr] <= period_ticks;
		end
		if (lr_we) begin
			last_mem[lr_addr] <= lr_data;
		end
		if (rd_en) begin
			period_rd_q <= period_mem[rd_addr];
			last_rd_q   <= last_mem[rd_addr];
		end
	end

	// result selection
	always_comb begin
		o_strobe = 1'b0;
		o_slot   = '0;
		o_status = STATUS_OK;
		o_fired  = 1'b0;
		o_last   = 1'b0;
		if (cmd.accept) begin
			o_strobe = 1'b1;
			o_last   = 1'b1;
			case (mode) inside
				MODE_CREATE: begin
					if (table_full) begin
						o_status = STATUS_FULL;
					end else begin
						o_slot = SLOT_IO_W'(used_q);
					end
				end
				MODE_START, MODE_STOP: begin
					o_slot = slot_index;
					if (!idx_ok) begin
						o_status = STATUS_BAD_SLOT;
					end
				end
				MODE_RUN: begin
					if (used_q != '0) begin
						o_strobe = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan_eval) begin
			if (due && pend_valid_q) begin
				o_strobe = 1'b1;
				o_slot   = SLOT_IO_W'(pend_slot_q);
				o_fired  = 1'b1;
			end
		end else if (cmd.scan_finish) begin
			o_strobe = 1'b1;
			o_last   = 1'b1;
			if (pend_valid_q) begin
				o_slot  = SLOT_IO_W'(pend_slot_q);
				o_fired = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			used_q       <= '0;
			en_q         <= '0;
			eval_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			strobe_q     <= 1'b0;
			slot_out_q   <= '0;
			status_q     <= STATUS_OK;
			fired_q      <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			strobe_q   <= o_strobe;
			slot_out_q <= o_slot;
			status_q   <= o_status;
			fired_q    <= o_fired;
			last_q     <= o_last;
			if (cmd.accept) begin
				unique case (mode)
					MODE_TICK: begin
						tick_q <= tick_q + TICK_BITS'(1);
					end
					MODE_CREATE: begin
						if (!table_full) begin
							used_q         <= used_q + CNT_W'(1);
							en_q[new_addr] <= 1'b0;
						end
					end
					MODE_START: begin
						if (idx_ok) begin
							en_q[idx_addr] <= 1'b1;
						end
					end
					MODE_STOP: begin
						if (idx_ok) begin
							en_q[idx_addr] <= 1'b0;
						end
					end
					MODE_RUN: begin
						eval_idx_q   <= '0;
						pend_valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (cmd.scan_eval) begin
				eval_idx_q <= next_addr;
				if (due) begin
					pend_valid_q <= 1'b1;
					pend_slot_q  <= eval_idx_q;
				end
			end
		end
	end

	assign strobe      = strobe_q;
	assign slot_out    = slot_out_q;
	assign status      = status_q;
	assign fired       = fired_q;
	assign last_result = last_q;

endmodule

`default_nettype wire

// ----- src/periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler
// Tick counter and periodic task slot table with a sequential run pass.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on a rising edge with start high and busy low; mode,
//   slot_index and period_ticks are sampled then.
//   Each result shows on slot_out/status/fired/last_result for one cycle
//   with strobe high; last_result marks the final result of a command.
//   The receiver cannot stall; every strobe cycle is a transfer.
//   Tick, create, start, stop and undefined modes: one result in the cycle
//   after the transfer, busy stays low, so a command may follow every cycle.
//   Run: busy stays high while a pass steps over the created slots; the
//   pass reads one slot a cycle from the period and last-run tables (one
//   read port each) and compares in the next. A due slot is held until the
//   next due slot is found or the pass ends, and shows in the cycle after
//   that; the final one comes in the first cycle with busy low again.
//   Run with no created slots answers like the other modes.
//   Reset clears the tick counter, slot count and enable bits; the period
//   and last-run tables are written by create before any read.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_scheduler
	import pts_pkg::*;
#(
	parameter int MAX_SLOTS = 16,
	parameter int TICK_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [SLOT_IO_W-1:0] slot_index,
	input  wire logic [PERIOD_W-1:0]  period_ticks,
	output logic                      strobe,
	output logic [SLOT_IO_W-1:0]      slot_out,
	output logic [STATUS_W-1:0]       status,
	output logic                      fired,
	output logic                      last_result
);

	pts_cmd_t cmd;
	pts_sts_t sts;

	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	pts_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.TICK_BITS (TICK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.slot_index   (slot_index),
		.period_ticks (period_ticks),
		.strobe       (strobe),
		.slot_out     (slot_out),
		.status       (status),
		.fired        (fired),
		.last_result  (last_result)
	);

endmodule

`default_nettype wire

// ----- src/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the scheduler result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pts_checker
	import pts_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic [MODE_W-1:0]   mode,
	input wire logic                strobe,
	input wire logic [STATUS_W-1:0] status,
	input wire logic                fired,
	input wire logic                last_result
);

	`AST_NXT(a_single_answer, clk, arst_n, start && !busy && mode != MODE_RUN, strobe && last_result)
	`AST_IMP(a_plain_is_last, clk, arst_n, strobe && !fired, last_result)
	`AST_IMP(a_fired_ok, clk, arst_n, strobe && fired, status == STATUS_OK)
	`AST_IMP(a_mid_pass_busy, clk, arst_n, strobe && !last_result, busy)

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (.*);

`default_nettype wire
